FILE: sv/tcm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the touch calibration and mapping block.
package tcm_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int RAW_BITS      = 12;
    localparam int CAL_POINTS    = 4;

    localparam int SX_W     = $clog2(SCREEN_WIDTH);
    localparam int SY_W     = $clog2(SCREEN_HEIGHT);
    localparam int SCALE_W  = (SX_W > SY_W) ? SX_W : SY_W;
    localparam int NUM_W    = RAW_BITS + SCALE_W;
    localparam int CNT_W    = $clog2(NUM_W + 1);
    localparam int SIDX_W   = $clog2(CAL_POINTS);
    localparam int STEP_W   = 3;
    localparam int REG_IDX_W = 3;

    // action codes
    localparam logic [1:0] ACT_POLL  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_LOAD  = 2'd2;

    // cal_result codes
    localparam logic [1:0] RES_NONE   = 2'd0;
    localparam logic [1:0] RES_SAVED  = 2'd1;
    localparam logic [1:0] RES_FAILED = 2'd2;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_X_MIN    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_X_MAX    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_Y_MIN    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_Y_MAX    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SWAP     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MIN_SPAN = 3'd5;

    // register reset values
    localparam logic [RAW_BITS-1:0] RST_X_MIN    = RAW_BITS'(200);
    localparam logic [RAW_BITS-1:0] RST_X_MAX    = RAW_BITS'(3800);
    localparam logic [RAW_BITS-1:0] RST_Y_MIN    = RAW_BITS'(200);
    localparam logic [RAW_BITS-1:0] RST_Y_MAX    = RAW_BITS'(3800);
    localparam logic                RST_SWAP     = 1'b0;
    localparam logic [RAW_BITS-1:0] RST_MIN_SPAN = RAW_BITS'(300);

    // divider request
    typedef struct packed {
        logic                start;
        logic [NUM_W-1:0]    num;
        logic [RAW_BITS-1:0] den;
    } div_req_t;

endpackage

FILE: sv/tcm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for poll requests and status results.
interface tcm_poll_if
    import tcm_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [1:0]          action;
    logic                touched;
    logic [RAW_BITS-1:0] raw_x;
    logic [RAW_BITS-1:0] raw_y;

    modport source (output valid, output action, output touched, output raw_x,
                    output raw_y, input ready);
    modport sink   (input valid, input action, input touched, input raw_x,
                    input raw_y, output ready);
endinterface

interface tcm_status_if
    import tcm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              pressed;
    logic [SX_W-1:0]   screen_x;
    logic [SY_W-1:0]   screen_y;
    logic              calibrating;
    logic [STEP_W-1:0] cal_step;
    logic [1:0]        cal_result;

    modport source (output valid, output pressed, output screen_x, output screen_y,
                    output calibrating, output cal_step, output cal_result,
                    input ready);
    modport sink   (input valid, input pressed, input screen_x, input screen_y,
                    input calibrating, input cal_step, input cal_result,
                    output ready);
endinterface

FILE: sv/tcm_serial_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle.
module tcm_serial_div
    import tcm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    logic [NUM_W-1:0]    quo_reg;
    logic [RAW_BITS-1:0] rem_reg;
    logic [RAW_BITS-1:0] den_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                done_reg;

    logic [RAW_BITS:0] trial;
    logic [RAW_BITS:0] diff;
    logic              ge;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= CNT_W'(NUM_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? diff[RAW_BITS-1:0] : trial[RAW_BITS-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/touch_calibrate_and_map_top.sv
`timescale 1ns / 1ps
// Top level of the four-point touch calibration and screen mapping block.
//
// One poll request (action, touched, raw_x, raw_y) yields exactly one status
// result. Start, load and calibration-capture polls go from acceptance through
// the evaluation state to the emit state, which loads the output register, and
// the next poll is taken after that. The fourth corner passes through CAL1
// (swap detection and edge averaging) and CAL2 (span check) before emit.
// A mapped press goes through the evaluation, multiply and divide states: the
// two axes are divided side by side in bit-serial restoring dividers of NUM_W
// quotient bits (21 with a 12-bit raw value and a 320x240 screen), one quotient
// bit per cycle. A new poll is taken once the previous one has been handed to the
// output register, so the next poll may start while a result waits there; a
// result that cannot be handed over stalls the input until the output is read.
// Config writes load the default edges, swap flag and minimum span; the
// defaults reach the live calibration only through a load action.

module touch_calibrate_and_map_top
    import tcm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [RAW_BITS-1:0]  cfg_data,
    tcm_poll_if.sink             poll,
    tcm_status_if.source         status
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_EVAL = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_DIV  = 7'b0001000,
        ST_CAL1 = 7'b0010000,
        ST_CAL2 = 7'b0100000,
        ST_EMIT = 7'b1000000
    } state_t;

    state_t state_reg;

    // configuration
    logic [RAW_BITS-1:0] def_x_min_reg, def_x_max_reg, def_y_min_reg, def_y_max_reg;
    logic                def_swap_reg;
    logic [RAW_BITS-1:0] min_span_reg;

    // live calibration and capture state
    logic [RAW_BITS-1:0] edge_x_min_reg, edge_x_max_reg, edge_y_min_reg, edge_y_max_reg;
    logic                swap_reg;
    logic                cap_active_reg;
    logic                latch_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [RAW_BITS-1:0] sample_x_reg [CAL_POINTS];
    logic [RAW_BITS-1:0] sample_y_reg [CAL_POINTS];

    // latched request
    logic [1:0]          act_reg;
    logic                touched_reg;
    logic [RAW_BITS-1:0] rx_reg, ry_reg;

    // mapping operands
    logic [RAW_BITS-1:0] mag_x_reg, den_x_reg, mag_y_reg, den_y_reg;
    logic                neg_x_reg, neg_y_reg;

    // calibration intermediates
    logic [RAW_BITS-1:0] left_reg, right_reg, top_reg, bottom_reg;
    logic                cal_swap_reg;

    // pending result
    logic              res_pressed_reg;
    logic [SX_W-1:0]   res_sx_reg;
    logic [SY_W-1:0]   res_sy_reg;
    logic [1:0]        res_code_reg;

    // output register
    logic              out_valid_reg;
    logic              out_pressed_reg;
    logic [SX_W-1:0]   out_sx_reg;
    logic [SY_W-1:0]   out_sy_reg;
    logic              out_cal_reg;
    logic [STEP_W-1:0] out_step_reg;
    logic [1:0]        out_code_reg;

    function automatic logic [RAW_BITS-1:0] abs_diff(input logic [RAW_BITS-1:0] a,
                                                     input logic [RAW_BITS-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [RAW_BITS-1:0] avg2(input logic [RAW_BITS-1:0] a,
                                                 input logic [RAW_BITS-1:0] b);
        logic [RAW_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[RAW_BITS:1];
    endfunction

    // handshakes
    logic accept;
    logic emit_load;
    assign poll.ready = (state_reg == ST_IDLE);
    assign accept     = poll.valid && poll.ready;
    assign emit_load  = (state_reg == ST_EMIT) && (!out_valid_reg || status.ready);

    // evaluation-stage decode
    logic [RAW_BITS-1:0] ux, uy;
    logic                map_ok;
    logic                take_sample;
    logic                last_sample;
    assign ux          = swap_reg ? ry_reg : rx_reg;
    assign uy          = swap_reg ? rx_reg : ry_reg;
    assign map_ok      = touched_reg && (edge_x_max_reg != edge_x_min_reg)
                         && (edge_y_max_reg != edge_y_min_reg);
    assign take_sample = touched_reg && !latch_reg;
    assign last_sample = (step_reg[SIDX_W-1:0] == SIDX_W'(CAL_POINTS - 1));

    // calibration: swap detect and edge averaging
    logic                swap_det;
    logic [RAW_BITS-1:0] xs [CAL_POINTS];
    logic [RAW_BITS-1:0] ys [CAL_POINTS];
    assign swap_det = abs_diff(sample_x_reg[1], sample_x_reg[0])
                      < abs_diff(sample_y_reg[1], sample_y_reg[0]);
    always_comb
    begin
        for (int i = 0; i < CAL_POINTS; i++)
        begin
            xs[i] = swap_det ? sample_y_reg[i] : sample_x_reg[i];
            ys[i] = swap_det ? sample_x_reg[i] : sample_y_reg[i];
        end
    end

    logic span_fail;
    assign span_fail = (abs_diff(right_reg, left_reg) < min_span_reg)
                       || (abs_diff(bottom_reg, top_reg) < min_span_reg);

    // dividers, x and y in parallel
    div_req_t         div_x_req, div_y_req;
    logic             div_x_done, div_y_done;
    logic [NUM_W-1:0] quo_x, quo_y;

    assign div_x_req.start = (state_reg == ST_MUL);
    assign div_x_req.num   = NUM_W'(mag_x_reg) * NUM_W'(SCREEN_WIDTH - 1);
    assign div_x_req.den   = den_x_reg;
    assign div_y_req.start = (state_reg == ST_MUL);
    assign div_y_req.num   = NUM_W'(mag_y_reg) * NUM_W'(SCREEN_HEIGHT - 1);
    assign div_y_req.den   = den_y_reg;

    tcm_serial_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_x_req),
        .done     (div_x_done),
        .quotient (quo_x)
    );

    tcm_serial_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_y_req),
        .done     (div_y_done),
        .quotient (quo_y)
    );

    // clamp: opposite signs truncate to zero or below, so zero
    logic [SX_W-1:0] clamp_x;
    logic [SY_W-1:0] clamp_y;
    assign clamp_x = neg_x_reg ? '0 :
                     (quo_x > NUM_W'(SCREEN_WIDTH - 1)) ? SX_W'(SCREEN_WIDTH - 1) :
                     quo_x[SX_W-1:0];
    assign clamp_y = neg_y_reg ? '0 :
                     (quo_y > NUM_W'(SCREEN_HEIGHT - 1)) ? SY_W'(SCREEN_HEIGHT - 1) :
                     quo_y[SY_W-1:0];

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            def_x_min_reg  <= RST_X_MIN;
            def_x_max_reg  <= RST_X_MAX;
            def_y_min_reg  <= RST_Y_MIN;
            def_y_max_reg  <= RST_Y_MAX;
            def_swap_reg   <= RST_SWAP;
            min_span_reg   <= RST_MIN_SPAN;
            edge_x_min_reg <= RST_X_MIN;
            edge_x_max_reg <= RST_X_MAX;
            edge_y_min_reg <= RST_Y_MIN;
            edge_y_max_reg <= RST_Y_MAX;
            swap_reg       <= RST_SWAP;
            cap_active_reg <= 1'b0;
            latch_reg      <= 1'b0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_X_MIN:    def_x_min_reg <= cfg_data;
                    REG_X_MAX:    def_x_max_reg <= cfg_data;
                    REG_Y_MIN:    def_y_min_reg <= cfg_data;
                    REG_Y_MAX:    def_y_max_reg <= cfg_data;
                    REG_SWAP:     def_swap_reg  <= cfg_data[0];
                    REG_MIN_SPAN: min_span_reg  <= cfg_data;
                    default:      ;
                endcase
            end

            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (status.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                        state_reg <= ST_EVAL;
                end
                ST_EVAL:
                begin
                    state_reg <= ST_EMIT;
                    case (act_reg)
                        ACT_START:
                        begin
                            cap_active_reg <= 1'b1;
                            latch_reg      <= 1'b0;
                            step_reg       <= '0;
                        end
                        ACT_LOAD:
                        begin
                            edge_x_min_reg <= def_x_min_reg;
                            edge_x_max_reg <= def_x_max_reg;
                            edge_y_min_reg <= def_y_min_reg;
                            edge_y_max_reg <= def_y_max_reg;
                            swap_reg       <= def_swap_reg;
                        end
                        ACT_POLL:
                        begin
                            if (cap_active_reg)
                            begin
                                if (!touched_reg)
                                    latch_reg <= 1'b0;
                                else if (!latch_reg)
                                begin
                                    latch_reg <= 1'b1;
                                    step_reg  <= STEP_W'(step_reg[SIDX_W-1:0]) + STEP_W'(1);
                                    if (last_sample)
                                        state_reg <= ST_CAL1;
                                end
                            end
                            else if (map_ok)
                                state_reg <= ST_MUL;
                        end
                        default: ;
                    endcase
                end
                ST_MUL:
                    state_reg <= ST_DIV;
                ST_DIV:
                begin
                    if (div_x_done && div_y_done)
                        state_reg <= ST_EMIT;
                end
                ST_CAL1:
                    state_reg <= ST_CAL2;
                ST_CAL2:
                begin
                    // failure keeps capture open and takes a held finger as corner one
                    latch_reg <= 1'b0;
                    step_reg  <= '0;
                    if (!span_fail)
                    begin
                        edge_x_min_reg <= left_reg;
                        edge_x_max_reg <= right_reg;
                        edge_y_min_reg <= top_reg;
                        edge_y_max_reg <= bottom_reg;
                        swap_reg       <= cal_swap_reg;
                        cap_active_reg <= 1'b0;
                    end
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (emit_load)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg     <= poll.action;
            touched_reg <= poll.touched;
            rx_reg      <= poll.raw_x;
            ry_reg      <= poll.raw_y;
        end

        if (state_reg == ST_EVAL)
        begin
            res_pressed_reg <= 1'b0;
            res_sx_reg      <= '0;
            res_sy_reg      <= '0;
            res_code_reg    <= RES_NONE;

            if (act_reg == ACT_POLL && cap_active_reg && take_sample)
            begin
                sample_x_reg[step_reg[SIDX_W-1:0]] <= rx_reg;
                sample_y_reg[step_reg[SIDX_W-1:0]] <= ry_reg;
            end

            // magnitudes and sign of (raw - min) and (max - min)
            mag_x_reg <= abs_diff(ux, edge_x_min_reg);
            den_x_reg <= abs_diff(edge_x_max_reg, edge_x_min_reg);
            neg_x_reg <= (ux < edge_x_min_reg) ^ (edge_x_max_reg < edge_x_min_reg);
            mag_y_reg <= abs_diff(uy, edge_y_min_reg);
            den_y_reg <= abs_diff(edge_y_max_reg, edge_y_min_reg);
            neg_y_reg <= (uy < edge_y_min_reg) ^ (edge_y_max_reg < edge_y_min_reg);
        end

        if (state_reg == ST_DIV && div_x_done && div_y_done)
        begin
            res_pressed_reg <= 1'b1;
            res_sx_reg      <= clamp_x;
            res_sy_reg      <= clamp_y;
        end

        if (state_reg == ST_CAL1)
        begin
            cal_swap_reg <= swap_det;
            left_reg     <= avg2(xs[0], xs[3]);
            right_reg    <= avg2(xs[1], xs[2]);
            top_reg      <= avg2(ys[0], ys[1]);
            bottom_reg   <= avg2(ys[2], ys[3]);
        end

        if (state_reg == ST_CAL2)
            res_code_reg <= span_fail ? RES_FAILED : RES_SAVED;

        if (emit_load)
        begin
            out_pressed_reg <= res_pressed_reg;
            out_sx_reg      <= res_sx_reg;
            out_sy_reg      <= res_sy_reg;
            out_cal_reg     <= cap_active_reg;
            out_step_reg    <= step_reg;
            out_code_reg    <= res_code_reg;
        end
    end

    assign status.valid       = out_valid_reg;
    assign status.pressed     = out_pressed_reg;
    assign status.screen_x    = out_sx_reg;
    assign status.screen_y    = out_sy_reg;
    assign status.calibrating = out_cal_reg;
    assign status.cal_step    = out_step_reg;
    assign status.cal_result  = out_code_reg;

endmodule

FILE: tb/sv/touch_calibrate_and_map_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the touch calibration and mapping block.
module touch_calibrate_and_map_top_test
    import tcm_pkg::*;
;
    localparam logic [1:0] ACT_UNUSED = 2'd3;     // action code the block ignores
    localparam int REG_COUNT      = 6;
    localparam int RAW_MAX        = (1 << RAW_BITS) - 1;
    localparam int DRAIN_CYCLES   = 2 * (NUM_W + 5);
    localparam int HOLD_CYCLES    = 300;           // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 95;            // per phase

    typedef struct packed {
        logic [1:0]          action;
        logic                touched;
        logic [RAW_BITS-1:0] raw_x;
        logic [RAW_BITS-1:0] raw_y;
    } poll_t;

    typedef struct packed {
        logic              pressed;
        logic [SX_W-1:0]   screen_x;
        logic [SY_W-1:0]   screen_y;
        logic              calibrating;
        logic [STEP_W-1:0] cal_step;
        logic [1:0]        cal_result;
    } status_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [RAW_BITS-1:0]  cfg_data;

    tcm_poll_if   poll_ch ();
    tcm_status_if status_ch ();

    touch_calibrate_and_map_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .poll      (poll_ch),
        .status    (status_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: default registers, live calibration, capture state
    // ------------------------------------------------------------------
    logic [RAW_BITS-1:0] dflt_x_min = RST_X_MIN;
    logic [RAW_BITS-1:0] dflt_x_max = RST_X_MAX;
    logic [RAW_BITS-1:0] dflt_y_min = RST_Y_MIN;
    logic [RAW_BITS-1:0] dflt_y_max = RST_Y_MAX;
    logic                dflt_swap  = RST_SWAP;
    logic [RAW_BITS-1:0] span_min   = RST_MIN_SPAN;

    logic [RAW_BITS-1:0] e_xmin = RST_X_MIN;
    logic [RAW_BITS-1:0] e_xmax = RST_X_MAX;
    logic [RAW_BITS-1:0] e_ymin = RST_Y_MIN;
    logic [RAW_BITS-1:0] e_ymax = RST_Y_MAX;
    logic                axes_exch  = RST_SWAP;
    logic                cap_on     = 1'b0;
    logic                press_held = 1'b0;
    logic [STEP_W-1:0]   cap_step   = '0;
    logic [RAW_BITS-1:0] smp_x [CAL_POINTS];
    logic [RAW_BITS-1:0] smp_y [CAL_POINTS];

    // request stream and expected status results
    poll_t   poll_backlog[$];
    status_t expected_status[$];
    poll_t   next_poll;
    status_t want, got;

    int queued_items  = 0;
    int errors        = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_tag      = 0;
    int hold_seen;
    int hold_left;
    int idle_run;

    function automatic logic [RAW_BITS-1:0] absdiff(logic [RAW_BITS-1:0] a,
                                                    logic [RAW_BITS-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic void load_edges();
        e_xmin    = dflt_x_min;
        e_xmax    = dflt_x_max;
        e_ymin    = dflt_y_min;
        e_ymax    = dflt_y_max;
        axes_exch = dflt_swap;
    endfunction

    // (raw - lo) * (size - 1) / (hi - lo), truncated toward zero, clamped
    function automatic int map_axis(logic [RAW_BITS-1:0] raw, logic [RAW_BITS-1:0] lo,
                                    logic [RAW_BITS-1:0] hi, int size);
        longint num, den, v;
        num = (longint'(raw) - longint'(lo)) * longint'(size - 1);
        den = longint'(hi) - longint'(lo);
        v = num / den;
        if (v < 0)
            v = 0;
        if (v > size - 1)
            v = size - 1;
        return int'(v);
    endfunction

    // Fourth corner: swap detection, edge averaging, span check
    function automatic logic [1:0] close_capture();
        logic                exch;
        logic [RAW_BITS-1:0] xs [CAL_POINTS];
        logic [RAW_BITS-1:0] ys [CAL_POINTS];
        logic [RAW_BITS-1:0] left, right, top, bottom;
        exch = absdiff(smp_x[1], smp_x[0]) < absdiff(smp_y[1], smp_y[0]);
        for (int i = 0; i < CAL_POINTS; i++)
        begin
            xs[i] = exch ? smp_y[i] : smp_x[i];
            ys[i] = exch ? smp_x[i] : smp_y[i];
        end
        left   = RAW_BITS'(((RAW_BITS + 1)'(xs[0]) + xs[3]) >> 1);
        right  = RAW_BITS'(((RAW_BITS + 1)'(xs[1]) + xs[2]) >> 1);
        top    = RAW_BITS'(((RAW_BITS + 1)'(ys[0]) + ys[1]) >> 1);
        bottom = RAW_BITS'(((RAW_BITS + 1)'(ys[2]) + ys[3]) >> 1);
        if (absdiff(right, left) < span_min || absdiff(bottom, top) < span_min)
            return RES_FAILED;
        e_xmin    = left;
        e_xmax    = right;
        e_ymin    = top;
        e_ymax    = bottom;
        axes_exch = exch;
        return RES_SAVED;
    endfunction

    function automatic status_t predict_status(logic [1:0] action, logic touched,
                                               logic [RAW_BITS-1:0] rx,
                                               logic [RAW_BITS-1:0] ry);
        status_t             s;
        logic [RAW_BITS-1:0] ux, uy;
        s = '0;
        case (action)
            ACT_START:
            begin
                cap_on     = 1'b1;
                press_held = 1'b0;
                cap_step   = '0;
            end
            ACT_LOAD:
                load_edges();
            ACT_POLL:
            begin
                if (cap_on)
                begin
                    if (!touched)
                        press_held = 1'b0;
                    else if (!press_held)
                    begin
                        smp_x[cap_step[1:0]] = rx;
                        smp_y[cap_step[1:0]] = ry;
                        cap_step   = cap_step + 1'b1;
                        press_held = 1'b1;
                        if (cap_step >= CAL_POINTS)
                        begin
                            s.cal_result = close_capture();
                            cap_on       = (s.cal_result == RES_FAILED);
                            press_held   = 1'b0;
                            cap_step     = '0;
                        end
                    end
                end
                else if (touched && e_xmax != e_xmin && e_ymax != e_ymin)
                begin
                    ux = axes_exch ? ry : rx;
                    uy = axes_exch ? rx : ry;
                    s.pressed  = 1'b1;
                    s.screen_x = SX_W'(map_axis(ux, e_xmin, e_xmax, SCREEN_WIDTH));
                    s.screen_y = SY_W'(map_axis(uy, e_ymin, e_ymax, SCREEN_HEIGHT));
                end
            end
            default: ;   // unused code: no state change
        endcase
        s.calibrating = cap_on;
        s.cal_step    = cap_step;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued poll requests, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            poll_ch.valid <= 1'b0;
        else
        begin
            if (poll_ch.valid && poll_ch.ready)
                expected_status.push_back(predict_status(poll_ch.action, poll_ch.touched,
                                                         poll_ch.raw_x, poll_ch.raw_y));
            if (!poll_ch.valid || poll_ch.ready)
            begin
                if (poll_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_poll = poll_backlog.pop_front();
                    poll_ch.valid   <= 1'b1;
                    poll_ch.action  <= next_poll.action;
                    poll_ch.touched <= next_poll.touched;
                    poll_ch.raw_x   <= next_poll.raw_x;
                    poll_ch.raw_y   <= next_poll.raw_y;
                end
                else
                    poll_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random backpressure, long hold-off on request, checking
    // ------------------------------------------------------------------
    task automatic compare_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            status_ch.ready <= 1'b0;
            hold_seen       <= 0;
            hold_left       <= 0;
        end
        else
        begin
            if (status_ch.valid && status_ch.ready)
            begin
                if (expected_status.size() == 0)
                begin
                    $error("status result with no poll request outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    got.pressed     = status_ch.pressed;
                    got.screen_x    = status_ch.screen_x;
                    got.screen_y    = status_ch.screen_y;
                    got.calibrating = status_ch.calibrating;
                    got.cal_step    = status_ch.cal_step;
                    got.cal_result  = status_ch.cal_result;
                    compare_field("pressed", want.pressed, got.pressed);
                    compare_field("screen_x", want.screen_x, got.screen_x);
                    compare_field("screen_y", want.screen_y, got.screen_y);
                    compare_field("calibrating", want.calibrating, got.calibrating);
                    compare_field("cal_step", want.cal_step, got.cal_step);
                    compare_field("cal_result", want.cal_result, got.cal_result);
                end
            end
            if (hold_tag != hold_seen)
            begin
                hold_seen       <= hold_tag;
                hold_left       <= HOLD_CYCLES;
                status_ch.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left       <= hold_left - 1;
                status_ch.ready <= 1'b0;
            end
            else
                status_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run when no request moves on either side for too long
    initial
    begin
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((poll_ch.valid && poll_ch.ready) || (status_ch.valid && status_ch.ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_poll(logic [1:0] action, logic touched, int x, int y);
        poll_t p;
        p.action  = action;
        p.touched = touched;
        p.raw_x   = RAW_BITS'(x);
        p.raw_y   = RAW_BITS'(y);
        poll_backlog.push_back(p);
        if (action != ACT_UNUSED)
            queued_items++;
    endtask

    function automatic int rand_raw();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return RAW_MAX;
            default: return $urandom_range(0, RAW_MAX);
        endcase
    endfunction

    function automatic int jitter(int v);
        int t;
        t = v + int'($urandom_range(0, 40)) - 20;
        if (t < 0)
            t = 0;
        if (t > RAW_MAX)
            t = RAW_MAX;
        return t;
    endfunction

    // Four-corner capture: TL, TR, BR, BL, with held fingers and releases.
    // A partial one stops after one to three corners.
    task automatic queue_calibration(bit whole);
        int xl, xr, yt, yb, tmp, cx, cy, corners;
        bit exch, exact;
        xl    = $urandom_range(0, 1200);
        xr    = $urandom_range(2800, RAW_MAX);
        yt    = $urandom_range(0, 1200);
        yb    = $urandom_range(2800, RAW_MAX);
        exact = 1'b0;
        case ($urandom_range(0, 7))
            0: xr = xl + $urandom_range(0, 600);       // narrow x, may fail
            1: yb = yt + $urandom_range(0, 600);       // narrow y, may fail
            2:
            begin
                tmp = xl;                              // mirrored x
                xl  = xr;
                xr  = tmp;
            end
            3:
            begin
                tmp = yt;                              // mirrored y
                yt  = yb;
                yb  = tmp;
            end
            4:
            begin
                exact = 1'b1;                          // full-scale corners
                xl = 0; xr = RAW_MAX; yt = 0; yb = RAW_MAX;
            end
            default: ;
        endcase
        exch    = ($urandom_range(0, 2) == 0);
        corners = whole ? CAL_POINTS : $urandom_range(1, CAL_POINTS - 1);
        push_poll(ACT_START, 1'($urandom_range(0, 1)), rand_raw(), rand_raw());
        for (int i = 0; i < corners; i++)
        begin
            cx = (i == 0 || i == 3) ? xl : xr;
            cy = (i < 2) ? yt : yb;
            if (!exact)
            begin
                cx = jitter(cx);
                cy = jitter(cy);
            end
            if (exch)
                push_poll(ACT_POLL, 1'b1, cy, cx);
            else
                push_poll(ACT_POLL, 1'b1, cx, cy);
            // finger stays down: ignored during capture, mapped or recaptured after
            repeat ($urandom_range(0, 2))
                push_poll(ACT_POLL, 1'b1, rand_raw(), rand_raw());
            if (i < CAL_POINTS - 1)
                repeat ($urandom_range(1, 2))
                    push_poll(ACT_POLL, 1'b0, rand_raw(), rand_raw());
        end
    endtask

    task automatic queue_directed();
        // mapping with reset calibration: clamp low, clamp high, release, unused code
        push_poll(ACT_POLL, 1'b1, 0, 0);
        push_poll(ACT_POLL, 1'b1, RAW_MAX, RAW_MAX);
        push_poll(ACT_POLL, 1'b0, 2000, 2000);
        push_poll(ACT_UNUSED, 1'b1, 2000, 2000);
        // clean capture; second touch of the first corner is held and ignored
        push_poll(ACT_START, 1'b0, 0, 0);
        push_poll(ACT_POLL, 1'b1, 300, 300);
        push_poll(ACT_POLL, 1'b1, 900, 900);
        push_poll(ACT_POLL, 1'b0, 0, 0);
        push_poll(ACT_POLL, 1'b1, 3700, 310);
        push_poll(ACT_POLL, 1'b0, 0, 0);
        push_poll(ACT_POLL, 1'b1, 3690, 3700);
        push_poll(ACT_POLL, 1'b0, 0, 0);
        push_poll(ACT_POLL, 1'b1, 310, 3690);
        push_poll(ACT_POLL, 1'b1, 2000, 1000);
        // swapped axes, span too small: fails and restarts capture
        push_poll(ACT_START, 1'b1, 0, 0);
        push_poll(ACT_POLL, 1'b1, 500, 500);
        push_poll(ACT_POLL, 1'b0, 0, 0);
        push_poll(ACT_POLL, 1'b1, 510, 700);
        push_poll(ACT_POLL, 1'b0, 0, 0);
        push_poll(ACT_POLL, 1'b1, 700, 690);
        push_poll(ACT_POLL, 1'b0, 0, 0);
        push_poll(ACT_POLL, 1'b1, 690, 510);
        // finger still down after the failure becomes the next first sample
        push_poll(ACT_POLL, 1'b1, 700, 700);
        // load during capture leaves the capture running
        push_poll(ACT_LOAD, 1'b0, 0, 0);
    endtask

    task automatic queue_random(int n);
        int start;
        start = queued_items;
        push_poll(ACT_LOAD, 1'($urandom_range(0, 1)), rand_raw(), rand_raw());
        while (queued_items - start < n)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: queue_calibration(1'b1);
                3, 4, 5, 6:
                    repeat ($urandom_range(3, 10))
                        push_poll(ACT_POLL, $urandom_range(0, 3) != 0, rand_raw(), rand_raw());
                7: push_poll(ACT_LOAD, 1'($urandom_range(0, 1)), rand_raw(), rand_raw());
                8:
                    repeat ($urandom_range(1, 4))
                        push_poll(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                  rand_raw(), rand_raw());
                default: queue_calibration(1'b0);
            endcase
        end
    endtask

    // one register write per clock; the predictor copy follows immediately
    task automatic set_reg(logic [REG_IDX_W-1:0] idx, logic [RAW_BITS-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_X_MIN:    dflt_x_min = val;
            REG_X_MAX:    dflt_x_max = val;
            REG_Y_MIN:    dflt_y_min = val;
            REG_Y_MAX:    dflt_y_max = val;
            REG_SWAP:     dflt_swap  = val[0];
            REG_MIN_SPAN: span_min   = val;
            default: ;    // index past the last register is dropped
        endcase
    endtask

    task automatic write_config(int x0, int x1, int y0, int y1, bit sw, int span);
        set_reg(REG_X_MIN, RAW_BITS'(x0));
        set_reg(REG_X_MAX, RAW_BITS'(x1));
        set_reg(REG_Y_MIN, RAW_BITS'(y0));
        set_reg(REG_Y_MAX, RAW_BITS'(y1));
        set_reg(REG_SWAP, RAW_BITS'({$urandom(), sw}));   // upper bits must be ignored
        set_reg(REG_MIN_SPAN, RAW_BITS'(span));
        set_reg(REG_IDX_W'(REG_COUNT + $urandom_range(0, 1)), RAW_BITS'($urandom()));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (poll_backlog.size() != 0 || poll_ch.valid || expected_status.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial
    begin
        int v;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_X_MIN;
        cfg_data          = '0;
        poll_ch.valid     = 1'b0;
        poll_ch.action    = ACT_POLL;
        poll_ch.touched   = 1'b0;
        poll_ch.raw_x     = '0;
        poll_ch.raw_y     = '0;
        status_ch.ready   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset calibration, directed cases, then random with a long hold-off
        set_idling(24, 60);
        queue_directed();
        queue_random(RANDOM_ITEMS);
        hold_tag++;
        wait_drained();

        // full-scale defaults, swap set, any span accepted
        write_config(0, RAW_MAX, 0, RAW_MAX, 1'b1, 0);
        set_idling(60, 24);
        queue_random(RANDOM_ITEMS);
        wait_drained();

        // mirrored full-scale defaults, widest span required
        write_config(RAW_MAX, 0, RAW_MAX, 0, 1'b0, RAW_MAX);
        queue_random(RANDOM_ITEMS);
        wait_drained();

        // degenerate x defaults
        v = rand_raw();
        write_config(v, v, rand_raw(), rand_raw(), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 600));
        set_idling(0, 0);
        queue_random(RANDOM_ITEMS);
        wait_drained();

        // random x defaults, degenerate y defaults
        v = rand_raw();
        write_config(rand_raw(), rand_raw(), v, v, 1'($urandom_range(0, 1)),
                     $urandom_range(0, 1500));
        queue_random(RANDOM_ITEMS);
        wait_drained();

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
